// ----- rtl/ssfm_pkg.sv -----
// Shared types and constants for the first-match substring search.
// No dependencies; used by every module of the block.
package ssfm_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int TEXT_MAX_DEF    = 65536;
    localparam int POS_W           = 16;
    localparam int BYTE_W          = 8;
    localparam int REQ_W           = 2;
    localparam int M_TDATA_W       = 24;

    typedef enum logic [REQ_W-1:0] {
        REQ_START   = 2'd0,
        REQ_PATTERN = 2'd1,
        REQ_TEXT    = 2'd2,
        REQ_FINISH  = 2'd3
    } req_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

endpackage

// ----- rtl/ssfm_cell.sv -----
// One search cell: a pattern byte and a window byte, compared against the
// aligned text byte. Depends on ssfm_pkg.
module ssfm_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ssfm_pkg::cell_ctrl_t           ctrl,
    input  logic                           pat_we,
    input  logic [ssfm_pkg::BYTE_W-1:0]    pat_byte,
    input  logic [ssfm_pkg::BYTE_W-1:0]    win_in,
    input  logic [ssfm_pkg::BYTE_W-1:0]    cmp_byte,
    input  logic                           active,
    output logic [ssfm_pkg::BYTE_W-1:0]    win_out,
    output logic                           hit
);

    logic [ssfm_pkg::BYTE_W-1:0] pat_reg;
    logic [ssfm_pkg::BYTE_W-1:0] win_reg;
    logic [ssfm_pkg::BYTE_W-1:0] win_next;

    always_comb begin
        win_next = win_reg;
        if (ctrl.clear) begin
            win_next = '0;
        end else if (ctrl.shift) begin
            win_next = win_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pat_we) begin
            pat_reg <= pat_byte;
        end
    end

    assign win_out = win_reg;
    assign hit     = !active || (cmp_byte == pat_reg);

endmodule

// ----- rtl/substring_search_first_match_top.sv -----
// Top level of the first-match substring search: control, cell row, result register.
// Depends on ssfm_pkg and ssfm_cell.
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | [7:0] data_byte                         | [1:0] req_type
//  m_      | out | [0] found, [16:1] match_position, [17] overflow | -
//
// One item per cycle; a text byte is shifted into the cell row and the whole
// window is compared with the pattern in the same cycle.
// A finish item loads its result into the output register, which presents it in the cycle after the item is accepted.
// Input stalls only while a result waits and m_tready is low.
// Reset clears lengths, counts, flags and window; pattern bytes are kept.
module substring_search_first_match_top #(
    parameter int PATTERN_MAX = ssfm_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = ssfm_pkg::TEXT_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ssfm_pkg::BYTE_W-1:0]       s_tdata,  // [7:0] data_byte
    input  logic [ssfm_pkg::REQ_W-1:0]        s_tuser,  // [1:0] req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ssfm_pkg::M_TDATA_W-1:0]    m_tdata   // found, match_position, overflow
);

    localparam int LW  = $clog2(PATTERN_MAX + 1);
    localparam int PIW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int TCW = $clog2(TEXT_MAX + 1);

    logic [LW-1:0]                  len_reg, len_next;
    logic [TCW-1:0]                 tc_reg, tc_next;
    logic                           match_reg, match_next;
    logic [ssfm_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                           ovf_reg, ovf_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [ssfm_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                           s_acc;
    ssfm_pkg::req_t                 req;
    logic                           text_ok;
    logic                           all_hit;
    logic [TCW-1:0]                 tc_inc;
    logic [31:0]                    pos_full;
    ssfm_pkg::cell_ctrl_t           ctrl;

    logic [ssfm_pkg::BYTE_W-1:0]    win_in   [PATTERN_MAX];
    logic [ssfm_pkg::BYTE_W-1:0]    win_out  [PATTERN_MAX];
    logic [ssfm_pkg::BYTE_W-1:0]    cmp_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]         active;
    logic [PATTERN_MAX-1:0]         pat_we;
    logic [PATTERN_MAX-1:0]         hit;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign req      = ssfm_pkg::req_t'(s_tuser);
    assign text_ok  = (32'(tc_reg) < 32'(TEXT_MAX));
    assign tc_inc   = tc_reg + TCW'(1);

    assign ctrl.clear = s_acc && (req == ssfm_pkg::REQ_START);
    assign ctrl.shift = s_acc && (req == ssfm_pkg::REQ_TEXT) && text_ok;

    always_comb begin
        logic [LW-1:0] idx;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            win_in[j] = (j == 0) ? s_tdata : win_out[(j == 0) ? 0 : j - 1];
        end
        for (int j = 0; j < PATTERN_MAX; j++) begin
            active[j]   = (32'(len_reg) > j);
            pat_we[j]   = s_acc && (req == ssfm_pkg::REQ_PATTERN) && (32'(len_reg) == j);
            idx         = len_reg - LW'(1) - LW'(j);
            cmp_byte[j] = active[j] ? win_in[idx[PIW-1:0]] : '0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
            ssfm_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .pat_we   (pat_we[g]),
                .pat_byte (s_tdata),
                .win_in   (win_in[g]),
                .cmp_byte (cmp_byte[g]),
                .active   (active[g]),
                .win_out  (win_out[g]),
                .hit      (hit[g])
            );
        end
    endgenerate

    assign all_hit  = &hit;
    assign pos_full = 32'(tc_inc) - 32'(len_reg);

    always_comb begin
        len_next      = len_reg;
        tc_next       = tc_reg;
        match_next    = match_reg;
        pos_next      = pos_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (s_acc) begin
            case (req)
                ssfm_pkg::REQ_START: begin
                    len_next   = '0;
                    tc_next    = '0;
                    match_next = 1'b0;
                    pos_next   = '0;
                    ovf_next   = 1'b0;
                end
                ssfm_pkg::REQ_PATTERN: begin
                    if (32'(len_reg) < 32'(PATTERN_MAX)) begin
                        len_next = len_reg + LW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                ssfm_pkg::REQ_TEXT: begin
                    if (!text_ok) begin
                        ovf_next = 1'b1;
                    end else begin
                        tc_next = tc_inc;
                        if (!match_reg && (len_reg != '0) && all_hit
                                && (32'(tc_inc) >= 32'(len_reg))) begin
                            match_next = 1'b1;
                            pos_next   = pos_full[ssfm_pkg::POS_W-1:0];
                        end
                    end
                end
                ssfm_pkg::REQ_FINISH: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[0] = match_reg || (len_reg == '0);
                    m_tdata_next[ssfm_pkg::POS_W:1] = match_reg ? pos_reg : '0;
                    m_tdata_next[ssfm_pkg::POS_W+1] = ovf_reg;
                end
                default: begin
                    m_tvalid_next = m_tvalid_reg && !m_tready;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            tc_reg       <= '0;
            match_reg    <= 1'b0;
            pos_reg      <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            len_reg      <= len_next;
            tc_reg       <= tc_next;
            match_reg    <= match_next;
            pos_reg      <= pos_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/ssfm_checker.sv -----
// Port-level checks for the substring search top level, bound to it below.
// Depends on ssfm_pkg and substring_search_first_match_top.
module ssfm_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ssfm_pkg::REQ_W-1:0]     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ssfm_pkg::M_TDATA_W-1:0] m_tdata
);

    logic s_acc;
    logic out_busy;

    assign s_acc    = s_tvalid && s_tready;
    assign out_busy = m_tvalid && !m_tready;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_busy |=> $stable(m_tdata) && m_tvalid)
        else $error("stalled result item changed");

    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_tuser == ssfm_pkg::REQ_FINISH) |=> m_tvalid)
        else $error("finish item gave no result");

    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_tuser != ssfm_pkg::REQ_FINISH) && !out_busy |=> !m_tvalid)
        else $error("result without a finish item");

    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> (m_tdata[ssfm_pkg::POS_W:1] == '0))
        else $error("position non-zero when not found");

endmodule

bind substring_search_first_match_top ssfm_checker u_ssfm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/substring_search_first_match_top_test.sv -----
// Self-checking testbench for substring_search_first_match_top: a stream of
// start, pattern, text and finish items with its own search predictor.
// Depends on ssfm_pkg and the block's RTL only.
module substring_search_first_match_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAT_MAX     = ssfm_pkg::PATTERN_MAX_DEF;
    localparam int TXT_MAX     = ssfm_pkg::TEXT_MAX_DEF;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic                       found;
        logic [ssfm_pkg::POS_W-1:0] position;
        logic                       overflow;
    } search_report_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ssfm_pkg::BYTE_W-1:0]    s_tdata = '0;
    logic [ssfm_pkg::REQ_W-1:0]     s_tuser = ssfm_pkg::REQ_START;
    logic                           m_tvalid;
    logic                           m_tready = 1'b1;
    logic [ssfm_pkg::M_TDATA_W-1:0] m_tdata;

    bit  idling_on = 1'b1;
    int  fail_count = 0;
    int  items_sent = 0;
    int  cycle_count = 0;

    search_report_t pending_reports[$];

    // predicted search state
    logic [7:0]                 pattern_bytes[PAT_MAX];
    int                         pattern_len = 0;
    logic [7:0]                 window_bytes[PAT_MAX];
    int                         text_total = 0;
    bit                         match_hit = 1'b0;
    logic [ssfm_pkg::POS_W-1:0] match_pos = '0;
    bit                         overflow_flag = 1'b0;

    substring_search_first_match_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic void predict_search(ssfm_pkg::req_t kind, logic [7:0] b);
        search_report_t r;
        bit ok;
        case (kind)
            ssfm_pkg::REQ_START: begin
                pattern_len = 0;
                text_total = 0;
                match_hit = 1'b0;
                match_pos = '0;
                overflow_flag = 1'b0;
                for (int i = 0; i < PAT_MAX; i++) window_bytes[i] = 8'h00;
            end
            ssfm_pkg::REQ_PATTERN: begin
                if (pattern_len < PAT_MAX) begin
                    pattern_bytes[pattern_len] = b;
                    pattern_len++;
                end else begin
                    overflow_flag = 1'b1;
                end
            end
            ssfm_pkg::REQ_TEXT: begin
                if (text_total >= TXT_MAX) begin
                    overflow_flag = 1'b1;
                end else begin
                    for (int i = PAT_MAX - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
                    window_bytes[0] = b;
                    text_total++;
                    if (!match_hit && pattern_len != 0 && text_total >= pattern_len) begin
                        ok = 1'b1;
                        for (int j = 0; j < pattern_len; j++)
                            if (window_bytes[pattern_len-1-j] != pattern_bytes[j]) ok = 1'b0;
                        if (ok) begin
                            match_hit = 1'b1;
                            match_pos = ssfm_pkg::POS_W'(text_total - pattern_len);
                        end
                    end
                end
            end
            default: begin
                r.found    = match_hit || (pattern_len == 0);
                r.position = match_hit ? match_pos : '0;
                r.overflow = overflow_flag;
                pending_reports.push_back(r);
            end
        endcase
    endfunction

    task automatic send_item(ssfm_pkg::req_t kind, logic [7:0] b);
        @(negedge aclk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_search(kind, b);
        items_sent++;
    endtask

    task automatic wait_for_reports();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    // result stalls
    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn && idling_on && $urandom_range(0, 3) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        search_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_tdata[0] !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[16:1] !== want.position) begin
                    $error("match_position: expected %0d, got %0d", want.position,
                           m_tdata[16:1]);
                    fail_count++;
                end
                if (m_tdata[17] !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, m_tdata[17]);
                    fail_count++;
                end
            end
        end
    end

    // empty pattern straight out of reset
    task automatic test_reset_report();
        send_item(ssfm_pkg::REQ_FINISH, 8'($urandom));
    endtask

    task automatic test_empty_pattern();
        send_item(ssfm_pkg::REQ_START, 8'hFF);
        send_item(ssfm_pkg::REQ_TEXT, 8'hFF);
        send_item(ssfm_pkg::REQ_TEXT, 8'h00);
        send_item(ssfm_pkg::REQ_FINISH, 8'h00);
    endtask

    // case-sensitive compare, byte extremes, repeated finish
    task automatic test_case_and_extremes();
        send_item(ssfm_pkg::REQ_START, 8'h00);
        send_item(ssfm_pkg::REQ_PATTERN, "a");
        send_item(ssfm_pkg::REQ_PATTERN, 8'hFF);
        send_item(ssfm_pkg::REQ_TEXT, "A");
        send_item(ssfm_pkg::REQ_TEXT, 8'hFF);
        send_item(ssfm_pkg::REQ_TEXT, "a");
        send_item(ssfm_pkg::REQ_TEXT, 8'hFF);
        send_item(ssfm_pkg::REQ_FINISH, 8'hFF);
        send_item(ssfm_pkg::REQ_FINISH, 8'h00);
    endtask

    // pattern grows after text has started
    task automatic test_late_pattern();
        send_item(ssfm_pkg::REQ_START, 8'h00);
        send_item(ssfm_pkg::REQ_PATTERN, 8'h5A);
        send_item(ssfm_pkg::REQ_TEXT, 8'h5B);
        send_item(ssfm_pkg::REQ_PATTERN, 8'h5B);
        send_item(ssfm_pkg::REQ_TEXT, 8'h5A);
        send_item(ssfm_pkg::REQ_TEXT, 8'h5B);
        send_item(ssfm_pkg::REQ_FINISH, 8'h00);
    endtask

    task automatic test_random_searches(int budget);
        logic [7:0] alpha[2];
        logic [7:0] pat[$];
        logic [7:0] txt[$];
        int stop_at, plen, tlen, at, extra_at, sel;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_item(ssfm_pkg::req_t'($urandom_range(0, 3)), 8'($urandom));
            end else begin
                alpha[0] = 8'($urandom);
                alpha[1] = ($urandom_range(0, 3) == 0) ? alpha[0] ^ 8'h20 : 8'($urandom);
                sel = $urandom_range(0, 19);
                plen = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(17, 18) :
                       (sel == 2) ? PAT_MAX : $urandom_range(1, 4);
                pat.delete();
                txt.delete();
                for (int i = 0; i < plen; i++) pat.push_back(alpha[$urandom_range(0, 1)]);
                tlen = $urandom_range(0, 20);
                for (int i = 0; i < tlen; i++) txt.push_back(alpha[$urandom_range(0, 1)]);
                if ($urandom_range(0, 1) == 1) begin
                    at = $urandom_range(0, tlen);
                    for (int k = 0; k < plen && k < PAT_MAX; k++) txt.insert(at + k, pat[k]);
                end
                extra_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, txt.size()) : -1;
                send_item(ssfm_pkg::REQ_START, 8'($urandom));
                foreach (pat[i]) send_item(ssfm_pkg::REQ_PATTERN, pat[i]);
                foreach (txt[i]) begin
                    if (i == extra_at)
                        send_item(ssfm_pkg::REQ_PATTERN, alpha[$urandom_range(0, 1)]);
                    send_item(ssfm_pkg::REQ_TEXT, txt[i]);
                end
                send_item(ssfm_pkg::REQ_FINISH, 8'($urandom));
                if ($urandom_range(0, 3) == 0) send_item(ssfm_pkg::REQ_FINISH, 8'($urandom));
            end
        end
    endtask

    // sender holds off until all reports are in, then restarts
    task automatic test_drained_restart();
        wait_for_reports();
        test_random_searches(150);
    endtask

    task automatic test_streaming_tail();
        idling_on = 1'b0;
        test_random_searches(100);
    endtask

    initial begin
        for (int i = 0; i < PAT_MAX; i++) begin
            pattern_bytes[i] = 8'h00;
            window_bytes[i]  = 8'h00;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_report();
        test_empty_pattern();
        test_case_and_extremes();
        test_late_pattern();
        test_random_searches(400);
        test_drained_restart();
        test_streaming_tail();

        wait_for_reports();
        repeat (8) @(posedge aclk);
        if (pending_reports.size() != 0) begin
            $error("%0d results never arrived", pending_reports.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
